[rtl/sdb_pkg.sv]
// Shared types, constants and elaboration-time functions for the dB display stretch.
`default_nettype none

package sdb_pkg;

  localparam int LOG_FRAC_W = 16;
  localparam int MANT_W     = 31;
  localparam int FRAC_STEPS = 16;

  // 10*log10(2) in Q16.
  localparam logic [17:0] DB_PER_LOG2_Q16 = 18'd197283;

  localparam logic [1:0] FMT_COMPLEX  = 2'd0;
  localparam logic [1:0] FMT_BYTE     = 2'd1;
  localparam logic [1:0] FMT_MONO16   = 2'd2;
  localparam logic [1:0] FMT_RESERVED = 2'd3;

  localparam logic [1:0] CFG_FORMAT = 2'd0;
  localparam logic [1:0] CFG_LO_DB  = 2'd1;
  localparam logic [1:0] CFG_HI_DB  = 2'd2;
  localparam logic [1:0] CFG_GAMMA  = 2'd3;

  typedef struct packed {
    logic       byp;
    logic [7:0] lvl;
  } sdb_side_t;

  function automatic logic [63:0] sdb_isqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    logic [63:0] xx;
    res = '0;
    b   = 64'd1 << 62;
    xx  = x;
    for (int i = 0; i < 32; i++) begin
      if (xx >= res + b) begin
        xx  = xx - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^-(2^-k) in Q30, built by repeated square roots starting from one half.
  function automatic logic [MANT_W-1:0] sdb_root_q30(input int k);
    logic [63:0] r;
    r = 64'd1 << 29;
    for (int j = 1; j <= FRAC_STEPS; j++) begin
      if (j <= k) begin
        r = sdb_isqrt(r << 30);
      end
    end
    return r[MANT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/sdb_log2.sv]
// Pipelined log2 in Q16: leading-one search, normalize, then one squaring per stage.
`default_nettype none

module sdb_log2
  import sdb_pkg::*;
#(
  parameter int IN_W = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  en,
  input  wire logic                                  in_valid,
  input  wire logic [IN_W-1:0]                       x,
  input  wire sdb_side_t                             sb_in,
  output logic                                       out_valid,
  output logic [$clog2(IN_W)+LOG_FRAC_W-1:0]         lg,
  output sdb_side_t                                  sb_out
);

  localparam int N_W = $clog2(IN_W);
  localparam int SH_W = IN_W + MANT_W;

  logic [N_W-1:0]  n_nxt;
  logic            v0_r;
  logic [IN_W-1:0] x0_r;
  logic [N_W-1:0]  n0_r;
  sdb_side_t       sb0_r;

  logic [SH_W-1:0] shifted;
  logic [N_W-1:0]  sh_amt;

  logic                  v_r  [0:FRAC_STEPS];
  logic [MANT_W-1:0]     m_r  [0:FRAC_STEPS];
  logic [LOG_FRAC_W-1:0] f_r  [0:FRAC_STEPS];
  logic [N_W-1:0]        n_r  [0:FRAC_STEPS];
  sdb_side_t             sb_r [0:FRAC_STEPS];

  always_comb begin
    n_nxt = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (x[i]) begin
        n_nxt = i[N_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r  <= x;
      n0_r  <= n_nxt;
      sb0_r <= sb_in;
    end
  end

  // Moving the leading one to the top gives the Q1.30 mantissa in the upper bits.
  assign sh_amt  = N_W'(IN_W - 1) - n0_r;
  assign shifted = {x0_r, {MANT_W{1'b0}}} << sh_amt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]  <= shifted[SH_W-1 -: MANT_W];
      f_r[0]  <= '0;
      n_r[0]  <= n0_r;
      sb_r[0] <= sb0_r;
    end
  end

  for (genvar j = 0; j < FRAC_STEPS; j++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     sq_hi;
    assign sq    = m_r[j] * m_r[j];
    assign sq_hi = sq[2*MANT_W-1:MANT_W-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[j+1]  <= sq_hi[MANT_W] ? sq_hi[MANT_W:1] : sq_hi[MANT_W-1:0];
        f_r[j+1]  <= {f_r[j][LOG_FRAC_W-2:0], sq_hi[MANT_W]};
        n_r[j+1]  <= n_r[j];
        sb_r[j+1] <= sb_r[j];
      end
    end
  end

  assign out_valid = v_r[FRAC_STEPS];
  assign lg        = {n_r[FRAC_STEPS], f_r[FRAC_STEPS]};
  assign sb_out    = sb_r[FRAC_STEPS];

  // A nonzero mantissa is always normalized with its top bit set.
  a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && (m_r[0] != '0) |-> m_r[0][MANT_W-1])
    else $error("log2 mantissa not normalized");

endmodule

`default_nettype wire

[rtl/sar_pixel_db_stretch_top.sv]
// Radar pixel to 8-bit display level: log magnitude, window, gamma, scale.
//
// Usage: samples enter on the in_ stream (first_part in in_tdata[31:0],
// second_part in in_tdata[63:32]); each word yields exactly one display level
// on the out_ stream. The block is a fixed pipeline of 77 register stages,
// and one word per clock is taken and delivered in steady state while the
// receiver does not stall the output. The depth is set by the two
// log2 units (16 squaring stages each), the 16-stage window divider and the
// 16-stage exponent product chain. The cfg_ port writes the format, window
// and gamma registers; write them only while no word is in flight.
// A synchronous low rst_n empties the pipeline and loads the register
// defaults: complex mode, window 0 to 60 dB, gamma 1.0. When the receiver
// holds out_tready low with a level waiting, the whole pipeline freezes and
// in_tready drops; while the output register holds no level the pipeline
// keeps moving and takes new words, and nothing is lost or repeated.
`default_nettype none

module sar_pixel_db_stretch_top
  import sdb_pkg::*;
#(
  parameter int DB_FRAC_BITS = 7
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] first_part, [63:32] second_part
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] display_level
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [16:0] cfg_wdata
);

  localparam int L1_W   = 6 + LOG_FRAC_W;
  localparam int PR_W   = L1_W + 18;
  localparam int DB_SH  = 32 - DB_FRAC_BITS;
  localparam int DB_W   = PR_W - DB_SH;
  localparam int NUM_W  = ((DB_W > 17) ? DB_W : 17) + 2;
  localparam int L2_W   = 4 + LOG_FRAC_W;
  localparam int T_W    = L2_W + 1;
  localparam int E_W    = T_W + 16 - 12;
  localparam int IP_W   = E_W - LOG_FRAC_W;
  localparam int DIV_N  = 16;

  // Configuration registers.
  logic [1:0]         fmt_r;
  logic signed [16:0] lo_r;
  logic signed [16:0] hi_r;
  logic [15:0]        gam_r;
  logic [16:0]        rng_r;
  logic signed [17:0] win_diff;
  logic [7:0]         zero_lvl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_COMPLEX;
      lo_r  <= 17'sd0;
      hi_r  <= 17'sd7680;
      gam_r <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FORMAT: fmt_r <= cfg_wdata[1:0];
        CFG_LO_DB:  lo_r  <= $signed(cfg_wdata);
        CFG_HI_DB:  hi_r  <= $signed(cfg_wdata);
        CFG_GAMMA:  gam_r <= cfg_wdata[15:0];
        default:    fmt_r <= fmt_r;
      endcase
    end
  end

  assign win_diff = {hi_r[16], hi_r} - {lo_r[16], lo_r};
  assign zero_lvl = (gam_r == 16'd0) ? 8'hFF : 8'h00;

  // Window span; an empty or inverted window counts as one dB.
  always_ff @(posedge clk) begin
    rng_r <= (hi_r > lo_r) ? win_diff[16:0] : 17'(1 << DB_FRAC_BITS);
  end

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 1: magnitudes and the formats that need no arithmetic.
  logic [31:0] a_re_nxt, a_im_nxt;
  sdb_side_t   side1_nxt;
  logic        v1_r;
  logic [31:0] a_re_r, a_im_r;
  sdb_side_t   side1_r;

  assign a_re_nxt = in_tdata[31] ? (~in_tdata[31:0] + 32'd1) : in_tdata[31:0];
  assign a_im_nxt = in_tdata[63] ? (~in_tdata[63:32] + 32'd1) : in_tdata[63:32];

  always_comb begin
    side1_nxt.byp = 1'b1;
    side1_nxt.lvl = 8'h00;
    unique case (fmt_r)
      FMT_COMPLEX: begin
        side1_nxt.byp = (in_tdata == 64'd0);
        side1_nxt.lvl = zero_lvl;
      end
      FMT_BYTE:   side1_nxt.lvl = in_tdata[7:0];
      FMT_MONO16: side1_nxt.lvl = in_tdata[15:8];
      default:    side1_nxt.lvl = 8'h00;
    endcase
  end

  // Stages 2 and 3: squares, then their sum.
  logic        v2_r, v3_r;
  logic [63:0] sq_re_r, sq_im_r, msq_r;
  sdb_side_t   side2_r, side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_re_r  <= a_re_nxt;
      a_im_r  <= a_im_nxt;
      side1_r <= side1_nxt;
      sq_re_r <= a_re_r * a_re_r;
      sq_im_r <= a_im_r * a_im_r;
      side2_r <= side1_r;
      msq_r   <= sq_re_r + sq_im_r;
      side3_r <= side2_r;
    end
  end

  // First log2: power in log2 units.
  logic            lg1_valid;
  logic [L1_W-1:0] lg1;
  sdb_side_t       lg1_side;

  sdb_log2 #(.IN_W(64)) u_log_pow (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .x         (msq_r),
    .sb_in     (side3_r),
    .out_valid (lg1_valid),
    .lg        (lg1),
    .sb_out    (lg1_side)
  );

  // Stage 4: convert to dB. Stage 5: place it in the window.
  logic                    v4_r, v5_r;
  logic [PR_W-1:0]         prod_db_r;
  sdb_side_t               side4_r, side5_r, side5_nxt;
  logic [DB_W-1:0]         db;
  logic signed [NUM_W-1:0] num_s;
  logic [16:0]             num_r;

  assign db    = prod_db_r[PR_W-1:DB_SH];
  assign num_s = $signed({{(NUM_W-DB_W){1'b0}}, db}) - $signed({{(NUM_W-17){lo_r[16]}}, lo_r});

  always_comb begin
    side5_nxt = side4_r;
    if (!side4_r.byp) begin
      if (num_s <= 0) begin
        side5_nxt.byp = 1'b1;
        side5_nxt.lvl = zero_lvl;
      end else if (num_s >= $signed({{(NUM_W-17){1'b0}}, rng_r})) begin
        side5_nxt.byp = 1'b1;
        side5_nxt.lvl = 8'hFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= lg1_valid;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_db_r <= lg1 * DB_PER_LOG2_Q16;
      side4_r   <= lg1_side;
      num_r     <= num_s[16:0];
      side5_r   <= side5_nxt;
    end
  end

  // Restoring divider: one quotient bit of num * 65536 / span per stage.
  logic        dv_r   [0:DIV_N];
  logic [16:0] rem_r  [0:DIV_N];
  logic [15:0] q_r    [0:DIV_N];
  sdb_side_t   dside_r[0:DIV_N];

  assign dv_r[0]    = v5_r;
  assign rem_r[0]   = num_r;
  assign q_r[0]     = '0;
  assign dside_r[0] = side5_r;

  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    logic [17:0] rem2;
    logic        qb;
    assign rem2 = {rem_r[i], 1'b0};
    assign qb   = (rem2 >= {1'b0, rng_r});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i+1] <= 1'b0;
      end else if (en) begin
        dv_r[i+1] <= dv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]   <= qb ? 17'(rem2 - {1'b0, rng_r}) : rem2[16:0];
        q_r[i+1]     <= {q_r[i][14:0], qb};
        dside_r[i+1] <= dside_r[i];
      end
    end
  end

  // A quotient of zero still means the bottom of the window.
  sdb_side_t side_q;
  always_comb begin
    side_q = dside_r[DIV_N];
    if (!side_q.byp && (q_r[DIV_N] == 16'd0)) begin
      side_q.byp = 1'b1;
      side_q.lvl = zero_lvl;
    end
  end

  logic            lg2_valid;
  logic [L2_W-1:0] lg2;
  sdb_side_t       lg2_side;

  sdb_log2 #(.IN_W(16)) u_log_lvl (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_r[DIV_N]),
    .x         (q_r[DIV_N]),
    .sb_in     (side_q),
    .out_valid (lg2_valid),
    .lg        (lg2),
    .sb_out    (lg2_side)
  );

  // Stage 7: t = -log2(v) in Q16. Stage 8: exponent e = t * gamma.
  logic                    v7_r, v8_r;
  logic [T_W-1:0]          t_r;
  logic [T_W+15:0]         e_full;
  logic [E_W-1:0]          e_r;
  sdb_side_t               side7_r, side8_r;

  assign e_full = t_r * gam_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v7_r <= lg2_valid;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= T_W'(16 << LOG_FRAC_W) - {1'b0, lg2};
      side7_r <= lg2_side;
      e_r     <= e_full[T_W+15:12];
      side8_r <= side7_r;
    end
  end

  // 2^-frac(e) as a product of fixed roots, one factor per stage.
  logic              xv_r   [0:FRAC_STEPS];
  logic [MANT_W-1:0] p_r    [0:FRAC_STEPS];
  logic [E_W-1:0]    xe_r   [0:FRAC_STEPS];
  sdb_side_t         xside_r[0:FRAC_STEPS];

  assign xv_r[0]    = v8_r;
  assign p_r[0]     = MANT_W'(1) << 30;
  assign xe_r[0]    = e_r;
  assign xside_r[0] = side8_r;

  for (genvar k = 1; k <= FRAC_STEPS; k++) begin : g_exp
    localparam logic [MANT_W-1:0] RK = sdb_root_q30(k);
    logic [2*MANT_W-1:0] pm;
    assign pm = p_r[k-1] * RK;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        xv_r[k] <= 1'b0;
      end else if (en) begin
        xv_r[k] <= xv_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[k]     <= xe_r[k-1][LOG_FRAC_W-k] ? pm[MANT_W+29:30] : p_r[k-1];
        xe_r[k]    <= xe_r[k-1];
        xside_r[k] <= xside_r[k-1];
      end
    end
  end

  // Integer part of e as a right shift, then scale by 255.
  logic              v9_r;
  logic [MANT_W-1:0] ps_r;
  sdb_side_t         side9_r;
  logic [IP_W-1:0]   ip;
  logic [MANT_W+7:0] scaled;
  logic [7:0]        level_nxt;

  assign ip     = xe_r[FRAC_STEPS][E_W-1:LOG_FRAC_W];
  assign scaled = {ps_r, 8'd0} - {8'd0, ps_r};
  assign level_nxt = side9_r.byp ? side9_r.lvl : scaled[37:30];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r       <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (en) begin
      v9_r       <= xv_r[FRAC_STEPS];
      out_tvalid <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps_r      <= (ip >= IP_W'(31)) ? '0 : (p_r[FRAC_STEPS] >> ip[4:0]);
      side9_r   <= xside_r[FRAC_STEPS];
      out_tdata <= level_nxt;
    end
  end

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[DIV_N] && !dside_r[DIV_N].byp |-> rem_r[DIV_N] < rng_r)
    else $error("divider remainder not below window span");

  a_pow_range: assert property (@(posedge clk) disable iff (!rst_n)
    v9_r |-> ps_r <= (MANT_W'(1) << 30))
    else $error("gamma power above one");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input held off without an output stall");

endmodule

`default_nettype wire

[dv/sar_pixel_db_stretch_checker.sv]
// Checker for the dB display stretch: predicts display levels and compares them.
`timescale 1ns / 100ps

module sar_pixel_db_stretch_checker
  import sdb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [16:0] cfg_wdata,
  output int               fail_count,
  output int               pending
);

  localparam int DB_FRAC = 7;

  logic [1:0]       fmt_q;
  longint           lo_q;
  longint           hi_q;
  longint unsigned  gamma_q;
  logic [7:0]       level_q[$];

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Integer part is the msb position; fraction bits come from repeated squaring.
  function automatic longint unsigned log2_fix(input longint unsigned x);
    int unsigned     n;
    longint unsigned m;
    longint unsigned frac;
    n = 63;
    frac = 0;
    while (n > 0 && x[n] == 1'b0) n--;
    if (n >= 30) m = x >> (n - 30);
    else m = x << (30 - n);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(n) << 16) | frac;
  endfunction

  function automatic longint unsigned pow2_neg(input longint unsigned e);
    longint unsigned p;
    longint unsigned r;
    p = 64'd1 << 30;
    r = 64'd1 << 29;
    for (int k = 1; k <= 16; k++) begin
      r = int_sqrt(r << 30);
      if (e[16-k]) p = (p * r) >> 30;
    end
    if ((e >> 16) >= 31) return 0;
    return p >> (e >> 16);
  endfunction

  function automatic logic [7:0] stretch_level(input logic [31:0] re_b, input logic [31:0] im_b);
    longint          re;
    longint          im;
    longint unsigned msq;
    longint          span;
    longint          db;
    longint          num;
    longint unsigned v;
    longint unsigned t;
    longint unsigned e;
    re = longint'($signed(re_b));
    im = longint'($signed(im_b));
    if (re < 0) re = -re;
    if (im < 0) im = -im;
    msq = longint'(re) * longint'(re);
    msq = msq + longint'(im) * longint'(im);
    span = (hi_q > lo_q) ? (hi_q - lo_q) : (64'sd1 << DB_FRAC);
    v = 0;
    if (msq != 0) begin
      db = longint'((log2_fix(msq) * 197283) >> (32 - DB_FRAC));
      num = db - lo_q;
      if (num <= 0) v = 0;
      else if (num >= span) v = 65536;
      else v = longint'((num * 65536) / span);
    end
    if (v == 0) return (gamma_q == 0) ? 8'd255 : 8'd0;
    if (v >= 65536) return 8'd255;
    t = (64'd16 << 16) - log2_fix(v);
    e = (t * gamma_q) >> 12;
    return 8'((pow2_neg(e) * 255) >> 30);
  endfunction

  function automatic logic [7:0] display_level_of(input logic [63:0] word);
    case (fmt_q)
      FMT_COMPLEX: return stretch_level(word[31:0], word[63:32]);
      FMT_BYTE:    return word[7:0];
      FMT_MONO16:  return word[15:8];
      default:     return 8'd0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  assign pending = level_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      fmt_q <= FMT_COMPLEX;
      lo_q <= 0;
      hi_q <= 7680;
      gamma_q <= 4096;
      level_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FORMAT: fmt_q <= cfg_wdata[1:0];
          CFG_LO_DB:  lo_q <= longint'($signed(cfg_wdata));
          CFG_HI_DB:  hi_q <= longint'($signed(cfg_wdata));
          CFG_GAMMA:  gamma_q <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) level_q.push_back(display_level_of(in_tdata));
      if (out_tvalid && out_tready) begin
        if (level_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0d", out_tdata));
        end else begin
          if (out_tdata !== level_q[0])
            report_mismatch($sformatf("display_level got %0d exp %0d", out_tdata, level_q[0]));
          void'(level_q.pop_front());
        end
      end
    end
  end

endmodule

[dv/sar_pixel_db_stretch_top_tb.sv]
// Testbench top for the dB display stretch: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module sar_pixel_db_stretch_top_tb;
  import sdb_pkg::*;

  localparam int PIPE_DEPTH = 77;
  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_FORMAT;
  logic [16:0] cfg_wdata = '0;
  int          fail_count;
  int          pending;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int          stall_cycles = 0;

  always #6 clk = ~clk;

  sar_pixel_db_stretch_top DUT (.*);

  sar_pixel_db_stretch_checker u_checker (.*);

  // Receiver: random backpressure, plus one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_req) begin
      out_tready <= 1'b0;
      repeat (300) @(negedge clk);
      hold_req = 1'b0;
    end else begin
      out_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 36);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_sample(input logic [31:0] first, input logic [31:0] second);
    while (!quiet && $urandom_range(0, 99) < 36) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {second, first};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Registers change only with the pipeline empty.
  task automatic write_reg(input logic [1:0] addr, input logic [16:0] val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_part();
    logic [31:0] mag;
    mag = $urandom >> $urandom_range(0, 31);
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  task automatic set_window(input logic [16:0] lo, input logic [16:0] hi, input logic [16:0] g);
    write_reg(CFG_LO_DB, lo);
    write_reg(CFG_HI_DB, hi);
    write_reg(CFG_GAMMA, g);
  endtask

  initial begin
    int lo;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, zero magnitude and field extremes.
    send_sample(32'd0, 32'd0);
    send_sample(32'h8000_0000, 32'h8000_0000);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'd0);
    send_sample(32'd1, 32'd0);
    send_sample(32'hFFFF_FFFF, 32'd0);
    send_sample(32'd0, 32'd1000);
    send_sample(32'd30000, 32'hFFFF_8AD0);
    set_window(17'd0, 17'd7680, 17'd0);        // gamma zero
    send_sample(32'd0, 32'd0);
    send_sample(32'd1000, 32'd0);
    set_window(17'd5000, 17'd5000, 17'hFFFF);  // empty window, largest gamma
    send_sample(32'd800, 32'd0);
    send_sample(32'd1000, 32'd3);
    set_window(17'h0FFFF, 17'h10000, 17'd2048); // inverted window, extremes
    send_sample(32'h7FFF_FFFF, 32'd5);
    set_window(17'h10000, 17'h0FFFF, 17'd4096);
    send_sample(32'd1, 32'd0);
    send_sample(32'h8000_0000, 32'd0);
    write_reg(CFG_FORMAT, FMT_BYTE);
    send_sample(32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_sample(32'h0000_00FF, 32'd0);
    write_reg(CFG_FORMAT, FMT_MONO16);
    send_sample(32'hFFFF_00FF, 32'd7);
    send_sample(32'h0000_FF00, 32'd0);
    write_reg(CFG_FORMAT, FMT_RESERVED);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random phases, mostly complex mode with assorted windows and gammas.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 7) write_reg(CFG_FORMAT, FMT_BYTE);
      else if (ph == 8) write_reg(CFG_FORMAT, FMT_MONO16);
      else write_reg(CFG_FORMAT, FMT_COMPLEX);
      if (ph % 3 == 2) begin
        set_window(17'($urandom), 17'($urandom), 17'(16'($urandom)));
      end else begin
        lo = $urandom_range(0, 6000) - 1000;
        set_window(17'(lo), 17'(lo + $urandom_range(0, 5000)),
                   17'($urandom_range(0, 16384)));
      end
      quiet = (ph == 4);
      if (ph == 5) hold_req = 1'b1;
      for (int i = 0; i < 200; i++) send_sample(rand_part(), rand_part());
    end
    quiet = 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
